// ===== rtl/acpm_pkg.sv =====
package acpm_pkg;

    // APB register file geometry
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Output field width
    localparam int PULSE_W = 16;
    localparam int PULSE_MAX = 65535;

    // RC pulse anchor values in microseconds
    typedef logic [10:0] t_rc;
    localparam t_rc RC_LOW  = 11'd1000;
    localparam t_rc RC_MID  = 11'd1500;
    localparam t_rc RC_HIGH = 11'd2000;

    // Pulse span of one segment and the bits it takes
    localparam int RC_SPAN   = 500;
    localparam int SPAN_BITS = 9;

    // Axis source codes
    typedef enum logic [1:0] {
        MODE_OFF     = 2'd0,
        MODE_ANALOG  = 2'd1,
        MODE_DIGITAL = 2'd2
    } t_mode;

    // Register indexes on paddr[3:2]
    typedef enum logic [1:0] {
        REG_MODE   = 2'd0,
        REG_LOW    = 2'd1,
        REG_CENTER = 2'd2,
        REG_HIGH   = 2'd3
    } t_reg_idx;

    // Sideband that rides along with each beat through the pipeline
    typedef struct packed {
        logic kill;   // quotient forced to zero, result is start
        logic qneg;   // quotient is negative
        t_rc  start;  // segment start value or fixed center result
    } t_meta;

endpackage

// ===== rtl/axis_calibrated_pulse_map.sv =====
// Channel   | Ports                                            | Beat taken when
// ----------+--------------------------------------------------+----------------------------
// sample in | start, busy, i_analog_sample, i_digital_level    | start && !busy
// pulse out | o_valid, o_pulse_width                           | o_valid (one cycle)
// config    | psel, penable, pwrite, paddr, pwdata, prdata,    | psel && penable && pwrite
//           | pready                                           |
//
// One sample enters every cycle while busy is low; its pulse passes through two setup
// stages, one stage per quotient bit of the restoring divider (SAMPLE_BITS + 9 bits),
// and one clamp stage.
// Reset is synchronous and active low; it empties the pipeline and holds busy high.
// The receiver cannot stall, so busy is never raised outside reset.
module axis_calibrated_pulse_map
    import acpm_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [SAMPLE_BITS-1:0] i_analog_sample,
    input  logic                   i_digital_level,
    output logic                   o_valid,
    output logic [PULSE_W-1:0]     o_pulse_width,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [PDATA_W-1:0]     pwdata,
    output logic [PDATA_W-1:0]     prdata,
    output logic                   pready
);

    localparam int QW  = SAMPLE_BITS + SPAN_BITS;
    localparam int LAT = QW + 3;

    logic [1:0]             cfg_mode;
    logic [SAMPLE_BITS-1:0] cfg_low, cfg_center, cfg_high;
    logic                   take;

    // Divider chain taps
    logic                   d_valid [QW+1];
    t_meta                  d_meta  [QW+1];
    logic [SAMPLE_BITS-1:0] d_den   [QW+1];
    logic [SAMPLE_BITS-1:0] d_rem   [QW+1];
    logic [QW-1:0]          d_work  [QW+1];

    assign busy = !i_rst_n;
    assign take = start && !busy;

    acpm_regs #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_mode   (cfg_mode),
        .o_low    (cfg_low),
        .o_center (cfg_center),
        .o_high   (cfg_high)
    );

    acpm_prep #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .QW          (QW)
    ) u_prep (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (take),
        .i_analog_sample (i_analog_sample),
        .i_digital_level (i_digital_level),
        .i_mode          (cfg_mode),
        .i_low           (cfg_low),
        .i_center        (cfg_center),
        .i_high          (cfg_high),
        .o_valid         (d_valid[0]),
        .o_meta          (d_meta[0]),
        .o_den           (d_den[0]),
        .o_num           (d_work[0])
    );

    assign d_rem[0] = '0;

    // One quotient bit per stage, most significant first
    for (genvar g = 0; g < QW; g++) begin : g_div
        acpm_div_stage #(
            .DW (SAMPLE_BITS),
            .QW (QW)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (d_valid[g]),
            .i_meta  (d_meta[g]),
            .i_den   (d_den[g]),
            .i_rem   (d_rem[g]),
            .i_work  (d_work[g]),
            .o_valid (d_valid[g+1]),
            .o_meta  (d_meta[g+1]),
            .o_den   (d_den[g+1]),
            .o_rem   (d_rem[g+1]),
            .o_work  (d_work[g+1])
        );
    end

    acpm_post #(
        .QW (QW)
    ) u_post (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (d_valid[QW]),
        .i_meta        (d_meta[QW]),
        .i_quot        (d_work[QW]),
        .o_valid       (o_valid),
        .o_pulse_width (o_pulse_width)
    );

    // Every output beat traces back to a sample taken a fixed latency earlier
    a_out_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(take, LAT))
        else $error("output beat without a matching input beat");

endmodule

// ===== rtl/acpm_regs.sv =====
module acpm_regs
    import acpm_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [PDATA_W-1:0]     pwdata,
    output logic [PDATA_W-1:0]     prdata,
    output logic                   pready,
    output logic [1:0]             o_mode,
    output logic [SAMPLE_BITS-1:0] o_low,
    output logic [SAMPLE_BITS-1:0] o_center,
    output logic [SAMPLE_BITS-1:0] o_high
);

    localparam logic [SAMPLE_BITS-1:0] CENTER_RST = SAMPLE_BITS'(2048);
    localparam logic [SAMPLE_BITS-1:0] HIGH_RST   = SAMPLE_BITS'(4095);

    logic [1:0]             r_mode;
    logic [SAMPLE_BITS-1:0] r_low;
    logic [SAMPLE_BITS-1:0] r_center;
    logic [SAMPLE_BITS-1:0] r_high;
    logic                   wr_en;
    t_reg_idx               idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = t_reg_idx'(paddr[3:2]);

    // Write the addressed register on the access beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_OFF;
            r_low    <= '0;
            r_center <= CENTER_RST;
            r_high   <= HIGH_RST;
        end else if (wr_en) begin
            unique case (idx)
                REG_MODE:   r_mode   <= pwdata[1:0];
                REG_LOW:    r_low    <= pwdata[SAMPLE_BITS-1:0];
                REG_CENTER: r_center <= pwdata[SAMPLE_BITS-1:0];
                REG_HIGH:   r_high   <= pwdata[SAMPLE_BITS-1:0];
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        unique case (idx)
            REG_MODE:   prdata = PDATA_W'(r_mode);
            REG_LOW:    prdata = PDATA_W'(r_low);
            REG_CENTER: prdata = PDATA_W'(r_center);
            REG_HIGH:   prdata = PDATA_W'(r_high);
        endcase
    end

    assign o_mode   = r_mode;
    assign o_low    = r_low;
    assign o_center = r_center;
    assign o_high   = r_high;

endmodule

// ===== rtl/acpm_prep.sv =====
module acpm_prep
    import acpm_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int QW          = SAMPLE_BITS + SPAN_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [SAMPLE_BITS-1:0] i_analog_sample,
    input  logic                   i_digital_level,
    input  logic [1:0]             i_mode,
    input  logic [SAMPLE_BITS-1:0] i_low,
    input  logic [SAMPLE_BITS-1:0] i_center,
    input  logic [SAMPLE_BITS-1:0] i_high,
    output logic                   o_valid,
    output t_meta                  o_meta,
    output logic [SAMPLE_BITS-1:0] o_den,
    output logic [QW-1:0]          o_num
);

    localparam int N = SAMPLE_BITS;

    // Stage A: pick reading, pick segment, form offsets
    logic [N-1:0]        ax;
    logic                neg_slope;
    logic                lower;
    logic signed [N:0]   sx, slo, smid, shi;
    logic signed [N:0]   n_a_diff, n_a_span;
    t_meta               n_a_meta;
    logic                r_a_valid;
    logic signed [N:0]   r_a_diff, r_a_span;
    t_meta               r_a_meta;

    always_comb begin
        if (i_mode == MODE_ANALOG) begin
            ax = i_analog_sample;
        end else if (i_mode == MODE_DIGITAL) begin
            ax = N'(i_digital_level);
        end else begin
            ax = '0;
        end
        neg_slope = i_low > i_high;
        lower     = neg_slope ? (ax > i_center) : (ax < i_center);
        sx        = $signed({1'b0, ax});
        slo       = $signed({1'b0, i_low});
        smid      = $signed({1'b0, i_center});
        shi       = $signed({1'b0, i_high});

        n_a_meta.qneg = 1'b0;
        priority if (ax == i_center) begin
            n_a_diff       = '0;
            n_a_span       = '0;
            n_a_meta.kill  = 1'b1;
            if (i_low == i_center) begin
                n_a_meta.start = RC_LOW;
            end else if (i_high == i_center) begin
                n_a_meta.start = RC_HIGH;
            end else begin
                n_a_meta.start = RC_MID;
            end
        end else if (lower) begin
            n_a_diff       = sx - slo;
            n_a_span       = smid - slo;
            n_a_meta.kill  = (i_low == i_center);
            n_a_meta.start = RC_LOW;
        end else begin
            n_a_diff       = sx - smid;
            n_a_span       = shi - smid;
            n_a_meta.kill  = (i_high == i_center);
            n_a_meta.start = RC_MID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_diff <= n_a_diff;
        r_a_span <= n_a_span;
        r_a_meta <= n_a_meta;
    end

    // Stage B: take magnitudes, scale offset by the pulse span RC_SPAN
    logic signed [N:0] neg_diff, neg_span;
    logic [N-1:0]      mag_diff, mag_span;
    logic [QW-1:0]     n_b_num;
    t_meta             n_b_meta;
    logic              r_b_valid;
    logic [N-1:0]      r_b_den;
    logic [QW-1:0]     r_b_num;
    t_meta             r_b_meta;

    always_comb begin
        neg_diff      = -r_a_diff;
        neg_span      = -r_a_span;
        mag_diff      = r_a_diff[N] ? neg_diff[N-1:0] : r_a_diff[N-1:0];
        mag_span      = r_a_span[N] ? neg_span[N-1:0] : r_a_span[N-1:0];
        n_b_num       = QW'(mag_diff) * QW'(RC_SPAN);
        n_b_meta      = r_a_meta;
        n_b_meta.qneg = r_a_diff[N] ^ r_a_span[N];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_den  <= mag_span;
        r_b_num  <= n_b_num;
        r_b_meta <= n_b_meta;
    end

    assign o_valid = r_b_valid;
    assign o_meta  = r_b_meta;
    assign o_den   = r_b_den;
    assign o_num   = r_b_num;

endmodule

// ===== rtl/acpm_div_stage.sv =====
module acpm_div_stage
    import acpm_pkg::*;
#(
    parameter int DW = 12,
    parameter int QW = 21
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  t_meta         i_meta,
    input  logic [DW-1:0] i_den,
    input  logic [DW-1:0] i_rem,
    input  logic [QW-1:0] i_work,
    output logic          o_valid,
    output t_meta         o_meta,
    output logic [DW-1:0] o_den,
    output logic [DW-1:0] o_rem,
    output logic [QW-1:0] o_work
);

    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW-1:0] n_rem;
    logic [QW-1:0] n_work;

    logic          r_valid;
    t_meta         r_meta;
    logic [DW-1:0] r_den;
    logic [DW-1:0] r_rem;
    logic [QW-1:0] r_work;

    // Shift in the next dividend bit, subtract when it fits, shift in quotient bit
    always_comb begin
        trial  = {i_rem, i_work[QW-1]};
        diff   = trial - {1'b0, i_den};
        ge     = !diff[DW];
        n_rem  = ge ? diff[DW-1:0] : trial[DW-1:0];
        n_work = {i_work[QW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_meta <= i_meta;
        r_den  <= i_den;
        r_rem  <= n_rem;
        r_work <= n_work;
    end

    assign o_valid = r_valid;
    assign o_meta  = r_meta;
    assign o_den   = r_den;
    assign o_rem   = r_rem;
    assign o_work  = r_work;

    // Partial remainder stays below the divisor on live divisions
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_meta.kill) |-> (r_rem < r_den))
        else $error("partial remainder not below divisor");

endmodule

// ===== rtl/acpm_post.sv =====
module acpm_post
    import acpm_pkg::*;
#(
    parameter int QW = 21
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_meta              i_meta,
    input  logic [QW-1:0]      i_quot,
    output logic               o_valid,
    output logic [PULSE_W-1:0] o_pulse_width
);

    localparam int SW = QW + 2;

    logic signed [SW-1:0] sq;
    logic signed [SW-1:0] sval;
    logic signed [SW-1:0] sstart;
    logic signed [SW-1:0] sum;
    logic [PULSE_W-1:0]   n_pulse;

    logic                 r_valid;
    logic [PULSE_W-1:0]   r_pulse;

    // Apply sign, add segment start, clamp to the pulse range
    always_comb begin
        sq     = i_meta.kill ? '0 : $signed({2'b00, i_quot});
        sval   = i_meta.qneg ? -sq : sq;
        sstart = $signed({{(SW - $bits(t_rc)){1'b0}}, i_meta.start});
        sum    = sval + sstart;
        priority if (sum[SW-1]) begin
            n_pulse = '0;
        end else if (sum > $signed(SW'(PULSE_MAX))) begin
            n_pulse = PULSE_W'(PULSE_MAX);
        end else begin
            n_pulse = sum[PULSE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pulse <= n_pulse;
    end

    assign o_valid       = r_valid;
    assign o_pulse_width = r_pulse;

    // A killed quotient yields exactly the carried start value
    a_kill_gives_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && $past(i_meta.kill))
            |-> (r_pulse == PULSE_W'($past(i_meta.start))))
        else $error("fixed result differs from carried start value");

endmodule
